// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define JRFC_ASSERT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define JRFC_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/jrfc_pkg.sv =====
// Shared types, constants and functions of the journal record checker.
package jrfc_pkg;

  localparam int unsigned HDR_BYTES  = 40;
  localparam int unsigned TRL_BYTES  = 4;
  localparam int unsigned MIN_RECORD = HDR_BYTES + TRL_BYTES;
  localparam int unsigned LEN_W      = 17;   // holds any length plus header and trailer
  localparam int unsigned HDR_BASE   = 8;    // first header byte kept in flops
  localparam int unsigned HDR_KEEP   = 30;   // bytes 8..37

  localparam logic [31:0] CRC_POLY     = 32'hedb88320;
  localparam logic [31:0] MAGIC        = 32'h314a4d42;   // "BMJ1", little endian
  localparam logic [15:0] HDR_VERSION  = 16'd1;
  localparam logic [15:0] HDR_SIZE     = 16'd40;
  localparam logic [7:0]  COMMIT_MARK  = 8'ha5;
  localparam logic [7:0]  PATH_LEAD    = 8'h2f;          // '/'

  localparam logic [7:0] PHASE_FIRST_RST = 8'd0;
  localparam logic [7:0] PHASE_LAST_RST  = 8'd8;
  localparam logic [7:0] FMT_ONE_RST     = 8'd0;
  localparam logic [7:0] FMT_TWO_RST     = 8'd1;

  typedef enum logic [1:0] {
    REG_PHASE_FIRST,
    REG_PHASE_LAST,
    REG_FMT_ONE,
    REG_FMT_TWO
  } jrfc_reg_t;

  // Expected value of a fixed header byte.
  typedef struct packed {
    logic       chk;
    logic [7:0] val;
  } jrfc_expect_t;

  // Everything the verdict needs about a finished record.
  typedef struct packed {
    logic [31:0] seq;
    logic [7:0]  phase;
    logic [7:0]  fmt;
    logic [63:0] old_dig;
    logic [63:0] new_dig;
    logic [15:0] l1;
    logic [15:0] l2;
    logic [15:0] pay;
    logic [16:0] len;
    logic [31:0] crc;
    logic [31:0] trailer;
    logic        fixed_ok;
    logic        checks_ok;
  } jrfc_snap_t;

  // One byte handed from the parse stage to the check stage.
  typedef struct packed {
    logic       cmp;     // old path entry was read for this byte
    logic [7:0] nbyte;
    logic       last;
    jrfc_snap_t snap;    // meaningful on the last byte only
  } jrfc_item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic jrfc_expect_t hdr_expect(input logic [5:0] pos);
    jrfc_expect_t e;
    e.chk = 1'b1;
    e.val = '0;
    case (pos)
      6'd0:    e.val = MAGIC[7:0];
      6'd1:    e.val = MAGIC[15:8];
      6'd2:    e.val = MAGIC[23:16];
      6'd3:    e.val = MAGIC[31:24];
      6'd4:    e.val = HDR_VERSION[7:0];
      6'd5:    e.val = HDR_VERSION[15:8];
      6'd6:    e.val = HDR_SIZE[7:0];
      6'd7:    e.val = HDR_SIZE[15:8];
      6'd14:   e.val = COMMIT_MARK;
      6'd15:   e.val = '0;
      6'd38:   e.val = '0;
      6'd39:   e.val = '0;
      default: e.chk = 1'b0;
    endcase
    return e;
  endfunction

endpackage

// ===== hdl/jrfc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module jrfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/jrfc_front.sv =====
// Parse stage: byte position, header capture, CRC, path checks, old path store access.
`include "assert_macros.svh"

module jrfc_front #(
  parameter int MAX_PATH_BYTES   = 256,
  parameter int MAX_RECORD_BYTES = 1024,
  parameter int AW               = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic [7:0]           s_tdata,
  input  logic                 s_tlast,
  input  logic                 in_ready,
  output logic                 item_valid,
  output jrfc_pkg::jrfc_item_t item,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [7:0]           ram_wdata,
  output logic                 ram_re,
  output logic [AW-1:0]        ram_raddr
);
  import jrfc_pkg::*;

  localparam int PW = $clog2(MAX_RECORD_BYTES + 2);

  logic [PW-1:0]         pos;
  logic [PW-1:0]         pos_next;
  logic [8*HDR_KEEP-1:0] hdr;
  logic [8*HDR_KEEP-1:0] hdr_next;
  logic                  fixed_ok;
  logic                  fixed_ok_next;
  logic [31:0]           crc;
  logic [31:0]           crc_next;
  logic [31:0]           trailer;
  logic [31:0]           trailer_next;
  logic                  checks;
  logic                  checks_next;

  logic         accept;
  logic         take;
  logic [16:0]  p17;
  logic [16:0]  q17;
  logic [16:0]  r17;
  logic [15:0]  l1;
  logic [15:0]  l2;
  logic         in_hdr;
  logic         in_old;
  logic         in_new;
  logic         lead;
  logic         bad;
  jrfc_expect_t exp_b;

  assign accept = s_tvalid && in_ready;
  assign take   = accept && (pos <= PW'(MAX_RECORD_BYTES));
  assign p17    = 17'(pos);
  assign q17    = p17 - 17'(HDR_BYTES);
  assign l1     = hdr[8*(32-HDR_BASE) +: 16];
  assign l2     = hdr[8*(34-HDR_BASE) +: 16];
  assign r17    = q17 - 17'(l1);
  assign in_hdr = p17 < 17'(HDR_BYTES);
  assign in_old = !in_hdr && (q17 < 17'(l1));
  assign in_new = !in_hdr && !in_old && (r17 < 17'(l2));
  assign lead   = in_old ? (q17 == '0) : (r17 == '0);
  assign bad    = (lead && (s_tdata != PATH_LEAD)) || (s_tdata == '0);
  assign exp_b  = hdr_expect(pos[5:0]);

  always_comb begin
    hdr_next = hdr;
    for (int i = 0; i < HDR_KEEP; i++) begin
      if (take && (p17 == 17'(HDR_BASE + i))) begin
        hdr_next[8*i +: 8] = s_tdata;
      end
    end
  end

  always_comb begin
    pos_next      = take ? pos + PW'(1) : pos;
    trailer_next  = take ? {s_tdata, trailer[31:8]} : trailer;
    crc_next      = (take && (p17 >= 17'(TRL_BYTES))) ? crc_byte(crc, trailer[7:0]) : crc;
    fixed_ok_next = fixed_ok && !(take && in_hdr && exp_b.chk && (s_tdata != exp_b.val));
    checks_next   = checks && !(take && (in_old || in_new) && bad);
  end

  // Old path bytes are written, new path bytes read back for the compare.
  assign ram_we    = take && in_old && (q17 < 17'(MAX_PATH_BYTES));
  assign ram_waddr = q17[AW-1:0];
  assign ram_wdata = s_tdata;
  assign ram_re    = take && in_new && (r17 < 17'(l1)) && (r17 < 17'(MAX_PATH_BYTES));
  assign ram_raddr = r17[AW-1:0];

  always_comb begin
    item_valid          = accept;
    item.cmp            = ram_re;
    item.nbyte          = s_tdata;
    item.last           = s_tlast;
    item.snap.seq       = hdr_next[8*(8-HDR_BASE) +: 32];
    item.snap.phase     = hdr_next[8*(12-HDR_BASE) +: 8];
    item.snap.fmt       = hdr_next[8*(13-HDR_BASE) +: 8];
    item.snap.old_dig   = hdr_next[8*(16-HDR_BASE) +: 64];
    item.snap.new_dig   = hdr_next[8*(24-HDR_BASE) +: 64];
    item.snap.l1        = hdr_next[8*(32-HDR_BASE) +: 16];
    item.snap.l2        = hdr_next[8*(34-HDR_BASE) +: 16];
    item.snap.pay       = hdr_next[8*(36-HDR_BASE) +: 16];
    item.snap.len       = 17'(pos_next);
    item.snap.crc       = crc_next;
    item.snap.trailer   = trailer_next;
    item.snap.fixed_ok  = fixed_ok_next;
    item.snap.checks_ok = checks_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      pos      <= '0;
      hdr      <= '0;
      fixed_ok <= 1'b1;
      crc      <= '1;
      trailer  <= '0;
      checks   <= 1'b1;
    end else begin
      pos      <= pos_next;
      hdr      <= hdr_next;
      fixed_ok <= fixed_ok_next;
      crc      <= crc_next;
      trailer  <= trailer_next;
      checks   <= checks_next;
    end
  end

  `JRFC_ASSERT_NEXT(a_rearm, clk, rst, accept && s_tlast, pos == '0, "position not cleared after last byte")
  `JRFC_ASSERT(a_port_excl, clk, rst, ram_we, !ram_re, "old path store written and read together")

endmodule

// ===== hdl/jrfc_back.sv =====
// Check stage: path compare, verdict, config registers and result register.
`include "assert_macros.svh"

module jrfc_back #(
  parameter int MAX_PATH_BYTES   = 256,
  parameter int MAX_RECORD_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  jrfc_pkg::jrfc_item_t item,
  output logic                 in_ready,
  input  logic [7:0]           ram_rdata,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [199:0]         m_tdata,
  output logic [0:0]           m_tuser
);
  import jrfc_pkg::*;

  logic [7:0] phase_first;
  logic [7:0] phase_last;
  logic [7:0] fmt_one;
  logic [7:0] fmt_two;

  logic       s1_valid;
  jrfc_item_t s1;
  logic       differ;

  logic       out_free;
  logic       s1_go;
  logic       differ_all;
  logic       ok;
  jrfc_snap_t sn;

  assign sn         = s1.snap;
  assign out_free   = !m_tvalid || m_tready;
  assign s1_go      = s1_valid && (!s1.last || out_free);
  assign in_ready   = !s1_valid || s1_go;
  assign differ_all = differ || (s1.cmp && (ram_rdata != s1.nbyte));

  always_comb begin
    ok = (sn.len >= 17'(MIN_RECORD)) && (sn.len <= 17'(MAX_RECORD_BYTES))
      && sn.fixed_ok && sn.checks_ok
      && (sn.phase >= phase_first) && (sn.phase <= phase_last)
      && ((sn.fmt == fmt_one) || (sn.fmt == fmt_two))
      && (sn.l1 != '0) && (sn.l2 != '0)
      && (17'(sn.l1) <= 17'(MAX_PATH_BYTES)) && (17'(sn.l2) <= 17'(MAX_PATH_BYTES))
      && (17'(sn.pay) == 17'(sn.l1) + 17'(sn.l2))
      && (sn.len == 17'(sn.pay) + 17'(MIN_RECORD))
      && ((sn.crc ^ 32'hffffffff) == sn.trailer)
      && !((sn.l1 == sn.l2) && !differ_all);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_first <= PHASE_FIRST_RST;
      phase_last  <= PHASE_LAST_RST;
      fmt_one     <= FMT_ONE_RST;
      fmt_two     <= FMT_TWO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_FIRST: phase_first <= cfg_data;
        REG_PHASE_LAST:  phase_last  <= cfg_data;
        REG_FMT_ONE:     fmt_one     <= cfg_data;
        REG_FMT_TWO:     fmt_two     <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      differ   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (item_valid) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        differ <= s1.last ? 1'b0 : differ_all;
      end
      if (s1_go && s1.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      s1 <= item;
    end
    if (s1_go && s1.last) begin
      m_tuser <= ok;
      m_tdata <= {6'd0, sn.l2[8:0], sn.l1[8:0], sn.new_dig, sn.old_dig,
                  sn.fmt, sn.phase, sn.seq};
    end
  end

  `JRFC_ASSERT_NEXT(a_result, clk, rst, s1_go && s1.last, m_tvalid, "last byte left no result")
  `JRFC_ASSERT_NEXT(a_differ_clr, clk, rst, s1_go && s1.last, !differ, "path compare leaked into next record")

endmodule

// ===== hdl/journal_record_frame_checker.sv =====
// Top level of the journal record frame checker.
//
// Takes a journal record one byte per item on the s_ side (s_tlast on the last byte) and,
// for each record, returns one result item on the m_ side: m_tuser says whether the record
// is valid, m_tdata carries the decoded header fields (zero for header bytes that never
// arrived). A record is a 40-byte little-endian header ("BMJ1", version 1, size 40, commit
// mark 0xA5 at offset 14, zeros at 15 and 38..39, phase and format within the configured
// sets, path lengths 1..MAX_PATH_BYTES summing to the payload size), the old and new path,
// and a reflected CRC-32 over header and payload in the last four bytes. Both paths must
// start with '/', hold no zero byte and differ. A record longer than MAX_RECORD_BYTES is
// counted up to capacity and reported corrupt on its last byte.
// Rate: one byte per clock across records, back to back, unless the input stalls.
// The parse stage updates the position, header flops and CRC per byte and writes the old
// path into a MAX_PATH_BYTES x 8 RAM; a new path byte reads its old counterpart, and the
// compare resolves in the check stage in the next cycle. The verdict then goes into the
// output register, which raises m_tvalid; a last byte waits in the check stage while the
// output register still holds a result not yet taken. Input stalls only while a result
// waits in the output register and another last byte has reached the check stage. No
// clearing pass after reset: every old path entry is written within a record before it
// is read.
// Config: cfg_we writes cfg_data into register cfg_index (0 phase_first, 1 phase_last,
// 2 format code one, 3 format code two); write only while the block is idle.
module journal_record_frame_checker #(
  parameter int MAX_PATH_BYTES   = 256,
  parameter int MAX_RECORD_BYTES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  // input bytes
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,    // [7:0] data_byte
  input  logic         s_tlast,    // final_byte
  // results
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata,    // [31:0] sequence_number, [39:32] phase_code,
                                   // [47:40] format_code, [111:48] old_digest,
                                   // [175:112] new_digest, [184:176] old_path_length,
                                   // [193:185] new_path_length, [199:194] zero
  output logic [0:0]   m_tuser,    // [0] record_ok
  // configuration
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);
  import jrfc_pkg::*;

  localparam int AW = (MAX_PATH_BYTES > 1) ? $clog2(MAX_PATH_BYTES) : 1;

  logic       in_ready;
  logic       item_valid;
  jrfc_item_t item;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign s_tready = in_ready;

  // Parse stage: framing, header capture, CRC and path rules.
  jrfc_front #(
    .MAX_PATH_BYTES  (MAX_PATH_BYTES),
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES),
    .AW              (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .in_ready  (in_ready),
    .item_valid(item_valid),
    .item      (item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // Old path store; read data held while the check stage stalls.
  jrfc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PATH_BYTES)
  ) u_old_path (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Check stage: path compare, verdict and result register.
  jrfc_back #(
    .MAX_PATH_BYTES  (MAX_PATH_BYTES),
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .in_ready  (in_ready),
    .ram_rdata (ram_rdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== test/record_check_pkg.sv =====
`timescale 1ns / 100ps
// Verdict predictor and scoreboard for the journal record checker bench.
package record_check_pkg;
  import jrfc_pkg::*;

  localparam int unsigned PATH_BYTES   = 256;
  localparam int unsigned RECORD_BYTES = 1024;

  typedef struct packed {
    logic        ok;
    logic [31:0] seq;
    logic [7:0]  phase;
    logic [7:0]  fmt;
    logic [63:0] old_dig;
    logic [63:0] new_dig;
    logic [8:0]  old_len;
    logic [8:0]  new_len;
  } verdict_t;

  // reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc32_next(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  class record_verdicts;
    logic [7:0]  phase_lo, phase_hi, fmt_a, fmt_b;
    int unsigned pos;
    logic [7:0]  hdr [HDR_BYTES];
    logic [31:0] crc, tail;
    logic [7:0]  old_path [PATH_BYTES];
    bit          clean, differ;
    verdict_t    pending [$];
    int unsigned errors, records, good_records;

    function new();
      phase_lo = PHASE_FIRST_RST;
      phase_hi = PHASE_LAST_RST;
      fmt_a    = FMT_ONE_RST;
      fmt_b    = FMT_TWO_RST;
      foreach (old_path[i]) old_path[i] = '0;
      rearm();
    endfunction

    function void set_reg(jrfc_reg_t r, logic [7:0] v);
      case (r)
        REG_PHASE_FIRST: phase_lo = v;
        REG_PHASE_LAST:  phase_hi = v;
        REG_FMT_ONE:     fmt_a = v;
        REG_FMT_TWO:     fmt_b = v;
        default: ;
      endcase
    endfunction

    function void rearm();
      pos = 0;
      foreach (hdr[i]) hdr[i] = '0;
      crc    = '1;
      tail   = '0;
      clean  = 1'b1;
      differ = 1'b0;
    endfunction

    function int unsigned hdr16(int unsigned at);
      return 32'({hdr[at + 1], hdr[at]});
    endfunction

    function logic [31:0] hdr32(int unsigned at);
      return {hdr[at + 3], hdr[at + 2], hdr[at + 1], hdr[at]};
    endfunction

    function logic [63:0] hdr64(int unsigned at);
      return {hdr32(at + 4), hdr32(at)};
    endfunction

    // CRC lags four bytes behind: a byte enters it as it drops out of the trailer window
    function void take(logic [7:0] b);
      int unsigned q, l1, l2;
      if (pos >= TRL_BYTES) crc = crc32_next(crc, tail[7:0]);
      tail = {b, tail[31:8]};
      if (pos < HDR_BYTES) begin
        hdr[pos] = b;
      end else begin
        q  = pos - HDR_BYTES;
        l1 = hdr16(32);
        l2 = hdr16(34);
        if (q < l1) begin
          if ((q == 0 && b != PATH_LEAD) || b == 8'd0) clean = 1'b0;
          if (q < PATH_BYTES) old_path[q] = b;
        end else if (q - l1 < l2) begin
          q = q - l1;
          if ((q == 0 && b != PATH_LEAD) || b == 8'd0) clean = 1'b0;
          if (q < l1 && q < PATH_BYTES && old_path[q] != b) differ = 1'b1;
        end
      end
      pos++;
    endfunction

    function bit well_formed();
      int unsigned l1, l2, pay;
      l1  = hdr16(32);
      l2  = hdr16(34);
      pay = hdr16(36);
      if (pos < MIN_RECORD || pos > RECORD_BYTES) return 1'b0;
      if (hdr32(0) != MAGIC) return 1'b0;
      if (hdr16(4) != HDR_VERSION || hdr16(6) != HDR_SIZE || hdr[14] != COMMIT_MARK ||
          hdr[15] != 8'd0 || hdr16(38) != 0) return 1'b0;
      if (hdr[12] < phase_lo || hdr[12] > phase_hi) return 1'b0;
      if (hdr[13] != fmt_a && hdr[13] != fmt_b) return 1'b0;
      if (l1 == 0 || l2 == 0 || l1 > PATH_BYTES || l2 > PATH_BYTES) return 1'b0;
      if (pay != l1 + l2 || pos != HDR_BYTES + pay + TRL_BYTES) return 1'b0;
      if (~crc != tail) return 1'b0;
      if (!clean) return 1'b0;
      if (l1 == l2 && !differ) return 1'b0;
      return 1'b1;
    endfunction

    // one accepted input item
    function void note_byte(logic [7:0] b, logic last);
      verdict_t v;
      if (pos <= RECORD_BYTES) take(b);
      if (!last) return;
      v.ok      = well_formed();
      v.seq     = hdr32(8);
      v.phase   = hdr[12];
      v.fmt     = hdr[13];
      v.old_dig = hdr64(16);
      v.new_dig = hdr64(24);
      v.old_len = {hdr[33][0], hdr[32]};
      v.new_len = {hdr[35][0], hdr[34]};
      pending.push_back(v);
      rearm();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 40)
          $display("t=%0d: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // one accepted result item
    function void check_result(logic [199:0] d, logic ok);
      verdict_t v;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("t=%0d: unexpected result, expected none, actual ok=%0b tdata=%h",
                   $time, ok, d);
        return;
      end
      v = pending.pop_front();
      records++;
      if (v.ok) good_records++;
      compare_field("record_ok", 64'(v.ok), 64'(ok));
      compare_field("sequence_number", 64'(v.seq), 64'(d[31:0]));
      compare_field("phase_code", 64'(v.phase), 64'(d[39:32]));
      compare_field("format_code", 64'(v.fmt), 64'(d[47:40]));
      compare_field("old_digest", v.old_dig, d[111:48]);
      compare_field("new_digest", v.new_dig, d[175:112]);
      compare_field("old_path_length", 64'(v.old_len), 64'(d[184:176]));
      compare_field("new_path_length", 64'(v.new_len), 64'(d[193:185]));
    endfunction
  endclass

endpackage

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench top: drives framed journal records through the checker and scores each verdict.
module tb;
  import jrfc_pkg::*;
  import record_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;     // pipeline is two stages deep

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [199:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [7:0]   cfg_data = '0;

  record_verdicts verdicts = new();

  logic [7:0]  rec_bytes [$];      // record being built, first byte at index 0
  int unsigned tx_gap_pct = 14;    // sender idle chance per item, percent
  int unsigned rx_gap_pct = 50;    // receiver stall chance per cycle, percent
  bit          hold_results = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned random_bytes = 0;
  int unsigned cycles = 0;

  always #5 clk = ~clk;

  journal_record_frame_checker #(
    .MAX_PATH_BYTES  (PATH_BYTES),
    .MAX_RECORD_BYTES(RECORD_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Result side: random back-pressure, or a solid hold-off while hold_results is set.
  always @(negedge clk) begin
    m_tready <= !hold_results && ($urandom_range(99) >= rx_gap_pct);
  end

  // Monitor: input prediction first, then result check, both on the same rising edge.
  // A result is registered after its last byte is accepted, so the order never matters.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) verdicts.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) verdicts.check_result(m_tdata, m_tuser[0]);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("t=%0d: timeout, %0d verdicts still outstanding", $time,
               verdicts.pending.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  // Offer one item; entered and left at a falling edge. Valid stays high between
  // back-to-back items and drops only for a random gap.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_record();
    foreach (rec_bytes[i]) send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
  endtask

  // Stop offering, wait out every expected verdict, then let the pipe settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (verdicts.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(jrfc_reg_t r, logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    verdicts.set_reg(r, v);
    @(negedge clk);
  endtask

  // only called with the checker idle
  task automatic program_checker(logic [7:0] lo, logic [7:0] hi, logic [7:0] fa,
                                 logic [7:0] fb);
    write_reg(REG_PHASE_FIRST, lo);
    write_reg(REG_PHASE_LAST, hi);
    write_reg(REG_FMT_ONE, fa);
    write_reg(REG_FMT_TWO, fb);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- record builder

  function automatic void put16(int unsigned at, logic [15:0] v);
    rec_bytes[at]     = v[7:0];
    rec_bytes[at + 1] = v[15:8];
  endfunction

  function automatic void fill_bytes(int unsigned at, int unsigned n, logic [7:0] v);
    for (int unsigned i = 0; i < n; i++) rec_bytes[at + i] = v;
  endfunction

  // new path becomes a copy of the old one (equal lengths assumed)
  function automatic void copy_old_path(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      rec_bytes[HDR_BYTES + len + i] = rec_bytes[HDR_BYTES + i];
  endfunction

  // Header plus both paths, all fields consistent; no trailer yet.
  function automatic void make_record(int unsigned old_len, int unsigned new_len,
                                      logic [7:0] ph, logic [7:0] fm);
    int unsigned pay, at;
    bit          same;
    pay = old_len + new_len;
    rec_bytes.delete();
    for (int i = 0; i < 4; i++) rec_bytes.push_back(MAGIC[8*i +: 8]);
    rec_bytes.push_back(HDR_VERSION[7:0]);
    rec_bytes.push_back(HDR_VERSION[15:8]);
    rec_bytes.push_back(HDR_SIZE[7:0]);
    rec_bytes.push_back(HDR_SIZE[15:8]);
    repeat (4) rec_bytes.push_back(8'($urandom));     // sequence
    rec_bytes.push_back(ph);
    rec_bytes.push_back(fm);
    rec_bytes.push_back(COMMIT_MARK);
    rec_bytes.push_back(8'd0);
    repeat (16) rec_bytes.push_back(8'($urandom));    // both digests
    rec_bytes.push_back(8'(old_len));
    rec_bytes.push_back(8'(old_len >> 8));
    rec_bytes.push_back(8'(new_len));
    rec_bytes.push_back(8'(new_len >> 8));
    rec_bytes.push_back(8'(pay));
    rec_bytes.push_back(8'(pay >> 8));
    rec_bytes.push_back(8'd0);
    rec_bytes.push_back(8'd0);
    rec_bytes.push_back(PATH_LEAD);
    repeat (old_len - 1) rec_bytes.push_back(8'($urandom_range(255, 1)));
    rec_bytes.push_back(PATH_LEAD);
    repeat (new_len - 1) rec_bytes.push_back(8'($urandom_range(255, 1)));
    // equal-length paths that came out identical by chance: nudge one byte
    if (old_len == new_len && new_len > 1) begin
      same = 1'b1;
      for (int unsigned i = 1; i < new_len; i++)
        if (rec_bytes[HDR_BYTES + i] != rec_bytes[HDR_BYTES + old_len + i]) same = 1'b0;
      if (same) begin
        at = HDR_BYTES + old_len + 1;
        rec_bytes[at] = (rec_bytes[at] == 8'h01) ? 8'h02 : 8'h01;
      end
    end
  endfunction

  // append the CRC trailer over everything built so far
  function automatic void seal_record();
    logic [31:0] c;
    c = '1;
    foreach (rec_bytes[i]) c = crc32_next(c, rec_bytes[i]);
    c = ~c;
    for (int i = 0; i < 4; i++) rec_bytes.push_back(c[8*i +: 8]);
  endfunction

  // mostly short paths, now and then long ones up to the maximum
  function automatic int unsigned path_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return $urandom_range(PATH_BYTES, 65);
    if (r < 15) return $urandom_range(64, 13);
    return $urandom_range(12, 1);
  endfunction

  function automatic logic [7:0] legal_phase();
    if (verdicts.phase_lo <= verdicts.phase_hi)
      return 8'($urandom_range(verdicts.phase_hi, verdicts.phase_lo));
    return 8'($urandom);    // inverted range: nothing is legal anyway
  endfunction

  // Random record: a bit over half well formed, the rest damaged in one way
  // (truncation, bit flip, header field, path content, identical paths, length
  // fields) or plain noise.
  task automatic random_record();
    int unsigned kind, l1, l2, at, n;
    kind = $urandom_range(99);
    rec_bytes.delete();
    if (kind >= 90) begin
      n = $urandom_range(50, 1);
      repeat (n) rec_bytes.push_back(8'($urandom));
      return;
    end
    l1 = path_size();
    l2 = (kind >= 75 && kind < 80) ? l1 : path_size();
    make_record(l1, l2, legal_phase(), $urandom_range(1) ? verdicts.fmt_a : verdicts.fmt_b);
    if (kind >= 65 && kind < 70) begin
      // damage one checked header byte; CRC still matches
      case ($urandom_range(6))
        0:       at = $urandom_range(3);
        1:       at = $urandom_range(7, 4);
        2:       at = 14;
        3:       at = 15;
        4:       at = $urandom_range(39, 38);
        5:       at = 12;
        default: at = 13;
      endcase
      rec_bytes[at] = rec_bytes[at] ^ 8'($urandom_range(255, 1));
    end else if (kind >= 70 && kind < 75) begin
      if ($urandom_range(1)) begin
        at = HDR_BYTES + ($urandom_range(1) ? 0 : l1);
        rec_bytes[at] = 8'($urandom_range(255, 1));     // lead byte, may stay '/'
      end else begin
        at = HDR_BYTES + $urandom_range(l1 + l2 - 1);
        rec_bytes[at] = 8'd0;
      end
    end else if (kind >= 75 && kind < 80) begin
      copy_old_path(l1);
    end else if (kind >= 80 && kind < 85) begin
      case ($urandom_range(2))
        0:       put16(36, 16'(l1 + l2 + $urandom_range(3, 1)));
        1:       rec_bytes.push_back(8'($urandom));
        default: void'(rec_bytes.pop_back());
      endcase
    end else if (kind >= 85) begin
      n  = $urandom_range(1) ? 0 : $urandom_range(65535, PATH_BYTES + 1);
      at = $urandom_range(1) ? 32 : 34;
      put16(at, 16'(n));
    end
    seal_record();
    if (kind >= 55 && kind < 60) begin
      n = $urandom_range(rec_bytes.size() - 1, 1);
      while (rec_bytes.size() > n) void'(rec_bytes.pop_back());
    end else if (kind >= 60 && kind < 65) begin
      at = $urandom_range(rec_bytes.size() - 1);
      n  = $urandom_range(7);
      rec_bytes[at] = rec_bytes[at] ^ (8'h01 << n);
    end
  endtask

  task automatic random_batch(int unsigned count);
    repeat (count) begin
      random_record();
      random_bytes += rec_bytes.size();
      send_record();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [7:0] lo, hi;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- reset register values; sender idles a little, receiver a lot
    // shortest legal record, zero header fields
    make_record(1, 2, PHASE_FIRST_RST, FMT_ONE_RST);
    fill_bytes(8, 4, 8'h00);
    fill_bytes(16, 16, 8'h00);
    seal_record();
    send_record();
    // longest old path, all-ones fields, top phase and second format
    make_record(PATH_BYTES, 1, PHASE_LAST_RST, FMT_TWO_RST);
    fill_bytes(8, 4, 8'hff);
    fill_bytes(16, 16, 8'hff);
    fill_bytes(HDR_BYTES + 1, 4, 8'hff);
    seal_record();
    send_record();
    // equal lengths, different content: valid
    make_record(5, 5, PHASE_FIRST_RST, FMT_TWO_RST);
    seal_record();
    send_record();
    // one-byte record
    rec_bytes = '{8'hff};
    send_record();
    // one byte short of the minimum
    make_record(1, 2, PHASE_FIRST_RST, FMT_ONE_RST);
    seal_record();
    while (rec_bytes.size() > MIN_RECORD - 1) void'(rec_bytes.pop_back());
    send_record();
    // identical paths
    make_record(3, 3, PHASE_FIRST_RST, FMT_ONE_RST);
    copy_old_path(3);
    seal_record();
    send_record();
    // zero byte inside the new path
    make_record(4, 4, PHASE_FIRST_RST, FMT_ONE_RST);
    rec_bytes[HDR_BYTES + 6] = 8'd0;
    seal_record();
    send_record();
    // old path without its leading slash
    make_record(3, 2, PHASE_FIRST_RST, FMT_ONE_RST);
    rec_bytes[HDR_BYTES] = 8'h41;
    seal_record();
    send_record();
    // bad trailer
    make_record(2, 3, PHASE_FIRST_RST, FMT_ONE_RST);
    seal_record();
    rec_bytes[rec_bytes.size() - 1] = rec_bytes[rec_bytes.size() - 1] ^ 8'h80;
    send_record();
    // phase just above the range, then a format that is not accepted
    make_record(2, 2, 8'(PHASE_LAST_RST + 1), FMT_ONE_RST);
    seal_record();
    send_record();
    make_record(2, 2, PHASE_FIRST_RST, 8'h02);
    seal_record();
    send_record();
    // declared old path longer than the store, payload sum consistent
    make_record(6, 6, PHASE_FIRST_RST, FMT_ONE_RST);
    put16(32, 16'd300);
    put16(36, 16'd306);
    seal_record();
    send_record();
    // zero-length new path
    make_record(6, 6, PHASE_FIRST_RST, FMT_ONE_RST);
    put16(34, 16'd0);
    seal_record();
    send_record();
    // bytes past the declared payload
    make_record(3, 3, PHASE_FIRST_RST, FMT_ONE_RST);
    rec_bytes.push_back(PATH_LEAD);
    rec_bytes.push_back(PATH_LEAD);
    seal_record();
    send_record();
    // past capacity: count saturates, tail is ignored until the last byte
    make_record(4, 4, PHASE_FIRST_RST, FMT_ONE_RST);
    while (rec_bytes.size() < 1028) rec_bytes.push_back(8'($urandom));
    send_record();

    random_batch(1);
    drain();

    // --- full phase range, format codes 255 and 0x2a; roles of the idlers swapped
    tx_gap_pct = 50;
    rx_gap_pct = 14;
    program_checker(8'd0, 8'd255, 8'd255, 8'h2a);
    random_batch(4);
    drain();

    // --- inverted phase range, both formats equal; no idling
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    program_checker(8'd200, 8'd100, 8'd255, 8'd255);
    // long receiver hold-off while short records keep coming: the output
    // register and check stage fill and the input must stall
    fork
      begin
        hold_results = 1'b1;
        repeat (400) @(negedge clk);
        hold_results = 1'b0;
      end
      begin
        repeat (24) begin
          rec_bytes.delete();
          repeat ($urandom_range(3, 1)) rec_bytes.push_back(8'($urandom));
          send_record();
        end
      end
    join
    random_batch(2);
    drain();

    // --- random legal range and formats
    lo = 8'($urandom_range(255));
    hi = 8'($urandom_range(255, lo));
    program_checker(lo, hi, 8'($urandom), 8'($urandom));
    random_batch(3);
    drain();

    $display("Covered %0d records (%0d valid) in %0d bytes, %0d of them random,",
             verdicts.records, verdicts.good_records, bytes_sent, random_bytes);
    $display("over four register settings with stalls on both sides and a long hold-off.");
    if (verdicts.errors == 0 && verdicts.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/jrfc_pkg.sv
hdl/jrfc_ram.sv
hdl/jrfc_front.sv
hdl/jrfc_back.sv
hdl/journal_record_frame_checker.sv
test/record_check_pkg.sv
test/tb.sv
